FILE: hdl/timer_counter_pwm_postscaler_unit_macros.svh
// Assertion macros used by the timer checker file.
`ifndef TIMER_COUNTER_PWM_POSTSCALER_UNIT_MACROS_SVH
`define TIMER_COUNTER_PWM_POSTSCALER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define TCP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define TCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer check failed");

`endif

FILE: hdl/tcp_pkg.sv
// Shared types, codes and helper functions of the timer/counter unit.
`timescale 1ns / 1ps

package tcp_pkg;

    // Widths
    localparam int COUNT_BITS    = 8;
    localparam int TALLY_BITS    = 16;
    localparam int VALUE_BITS    = 8;
    localparam int PRESCALE_BITS = 10;
    localparam int DIV_BITS      = PRESCALE_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [TALLY_BITS-1:0]    t_tally;
    typedef logic [PRESCALE_BITS-1:0] t_prescale;
    typedef logic [DIV_BITS-1:0]      t_div;

    localparam t_count COUNT_MAX = '1;

    // Item opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_WR_A = 2'd1;
    localparam logic [1:0] OP_WR_B = 2'd2;

    // Timer modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CTC    = 2'd1;
    localparam logic [1:0] MODE_PWM    = 2'd2;

    // Output pin modes
    localparam logic [1:0] PIN_OFF    = 2'd0;
    localparam logic [1:0] PIN_NONINV = 2'd1;
    localparam logic [1:0] PIN_INV    = 2'd2;

    // Clock select codes
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;
    localparam logic [2:0] CS_MASK    = 3'h7;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMER_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLOCK_SELECT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_A_MODE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_B_MODE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_REQ_MATCHES  = 3'd4;

    // Prescaler divisor for a clock select code, 0 when stopped or for an unused code
    function automatic t_div divisor(input logic [2:0] cs);
        t_div d;
        case (cs & CS_MASK)
            CS_DIV1:    d = t_div'(1);
            CS_DIV8:    d = t_div'(8);
            CS_DIV64:   d = t_div'(64);
            CS_DIV256:  d = t_div'(256);
            CS_DIV1024: d = t_div'(1024);
            default:    d = '0;
        endcase
        return d;
    endfunction

    // Pin level for a pin mode and a compare level
    function automatic logic drive_pin(input logic [1:0] mode, input logic level);
        logic p;
        case (mode)
            PIN_NONINV: p = level;
            PIN_INV:    p = ~level;
            default:    p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/tcp_item_if.sv
// Input channel of the timer: one tick or compare write per transfer.
`timescale 1ns / 1ps

interface tcp_item_if;
    import tcp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: hdl/tcp_result_if.sv
// Result channel of the timer: count, events and pin levels per transfer.
`timescale 1ns / 1ps

interface tcp_result_if;
    import tcp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] count;
    logic                  overflow_event;
    logic                  compare_a_event;
    logic                  compare_b_event;
    logic                  pwm_out_a;
    logic                  pwm_out_b;

    modport source (output valid, output count, output overflow_event,
                    output compare_a_event, output compare_b_event,
                    output pwm_out_a, output pwm_out_b, input ready);
    modport sink   (input valid, input count, input overflow_event,
                    input compare_a_event, input compare_b_event,
                    input pwm_out_a, input pwm_out_b, output ready);
endinterface

FILE: hdl/tcp_prescaler.sv
// Clock prescaler: divides system ticks down to timer clocks.
`timescale 1ns / 1ps

module tcp_prescaler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic [2:0] i_clock_select,
    output logic       o_timer_clk
);
    import tcp_pkg::*;

    t_prescale r_count;
    t_prescale n_count;
    t_div      w_div;
    t_div      w_inc;
    logic      w_run;

    // Decode divisor and detect terminal count
    assign w_div       = divisor(i_clock_select);
    assign w_run       = i_tick && (w_div != '0);
    assign w_inc       = {1'b0, r_count} + t_div'(1);
    assign o_timer_clk = w_run && (w_inc >= w_div);

    // Restart on a timer clock, advance otherwise
    always_comb begin
        n_count = r_count;
        if (w_run) begin
            n_count = o_timer_clk ? '0 : w_inc[PRESCALE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule

FILE: hdl/timer_counter_pwm_postscaler_unit.sv
// Top level of the 8-bit timer/counter with prescaler, CTC postscaler and fast PWM.
`timescale 1ns / 1ps

// Each transfer on i_item is one system tick or one compare write, and each
// yields exactly one result transfer on o_result. The unit takes one item
// every cycle unless o_result stalls: an input register feeds a single pass
// of compare/increment logic that updates the timer state and loads the
// result register in the same cycle. A stall on o_result holds the result
// register, then the input register, and only then drops i_item.ready.
// Configuration writes on i_cfg_* take effect at the next edge and are
// meant to be made while no item is in flight.
module timer_counter_pwm_postscaler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcp_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [tcp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    tcp_item_if.sink                         i_item,
    tcp_result_if.source                     o_result
);
    import tcp_pkg::*;

    // Configuration registers
    logic [1:0]  r_timer_mode;
    logic [2:0]  r_clock_select;
    logic [1:0]  r_out_a_mode;
    logic [1:0]  r_out_b_mode;
    logic [15:0] r_required;

    // Input register
    logic                  r_in_valid;
    logic [1:0]            r_in_op;
    logic [VALUE_BITS-1:0] r_in_val;

    // Timer state
    t_count     r_count, n_count;
    t_count     r_act_a, n_act_a;
    t_count     r_act_b, n_act_b;
    t_count     r_pend_a, n_pend_a;
    t_count     r_pend_b, n_pend_b;
    t_tally     r_tally, n_tally;
    logic [1:0] r_pins, n_pins;

    // Result register
    logic   r_out_valid;
    t_count r_out_count;
    logic   r_out_ovf, r_out_ca, r_out_cb, r_out_pin_a, r_out_pin_b;

    logic   w_adv;
    logic   w_timer_clk;
    logic   n_ovf, n_ca, n_cb;
    t_count w_inc;
    t_count w_val;
    t_tally w_tally_inc;

    // Advance when the result register is free or being drained
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_mode   <= MODE_NORMAL;
            r_clock_select <= CS_STOP;
            r_out_a_mode   <= PIN_OFF;
            r_out_b_mode   <= PIN_OFF;
            r_required     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIMER_MODE:   r_timer_mode   <= i_cfg_data[1:0];
                REG_CLOCK_SELECT: r_clock_select <= i_cfg_data[2:0];
                REG_OUT_A_MODE:   r_out_a_mode   <= i_cfg_data[1:0];
                REG_OUT_B_MODE:   r_out_b_mode   <= i_cfg_data[1:0];
                REG_REQ_MATCHES:  r_required     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Capture input transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op  <= i_item.opcode;
            r_in_val <= i_item.value;
        end
    end

    tcp_prescaler u_prescaler (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (w_adv && (r_in_op == OP_TICK)),
        .i_clock_select (r_clock_select),
        .o_timer_clk    (w_timer_clk)
    );

    assign w_inc       = r_count + t_count'(1);
    assign w_val       = t_count'(r_in_val);
    assign w_tally_inc = r_tally + t_tally'(1);

    // Next timer state and events for the item in the input register
    always_comb begin
        n_count  = r_count;
        n_act_a  = r_act_a;
        n_act_b  = r_act_b;
        n_pend_a = r_pend_a;
        n_pend_b = r_pend_b;
        n_tally  = r_tally;
        n_pins   = r_pins;
        n_ovf    = 1'b0;
        n_ca     = 1'b0;
        n_cb     = 1'b0;
        case (r_in_op)
            OP_WR_A: begin
                n_pend_a = w_val;
                if (r_timer_mode != MODE_PWM) begin
                    n_act_a = w_val;
                end
            end
            OP_WR_B: begin
                n_pend_b = w_val;
                if (r_timer_mode != MODE_PWM) begin
                    n_act_b = w_val;
                end
            end
            OP_TICK: begin
                if (w_timer_clk) begin
                    n_ovf = (r_count == COUNT_MAX);
                    if (r_timer_mode == MODE_CTC) begin
                        if (r_count == r_act_a) begin
                            n_count = '0;
                            if (32'(w_tally_inc) >= 32'(r_required)) begin
                                n_ca    = 1'b1;
                                n_tally = '0;
                            end else begin
                                n_tally = w_tally_inc;
                            end
                        end else begin
                            n_count = w_inc;
                        end
                    end else begin
                        n_count = w_inc;
                        if (r_timer_mode == MODE_PWM) begin
                            // Load buffered compares at the wrap
                            if (n_ovf) begin
                                n_act_a = r_pend_a;
                                n_act_b = r_pend_b;
                            end
                            n_ca   = (w_inc == n_act_a);
                            n_cb   = (w_inc == n_act_b);
                            n_pins = {w_inc <= n_act_b, w_inc <= n_act_a};
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Commit timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_act_a  <= '0;
            r_act_b  <= '0;
            r_pend_a <= '0;
            r_pend_b <= '0;
            r_tally  <= '0;
            r_pins   <= '0;
        end else if (w_adv) begin
            r_count  <= n_count;
            r_act_a  <= n_act_a;
            r_act_b  <= n_act_b;
            r_pend_a <= n_pend_a;
            r_pend_b <= n_pend_b;
            r_tally  <= n_tally;
            r_pins   <= n_pins;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_count <= n_count;
            r_out_ovf   <= n_ovf;
            r_out_ca    <= n_ca;
            r_out_cb    <= n_cb;
            r_out_pin_a <= (r_timer_mode == MODE_PWM) ? drive_pin(r_out_a_mode, n_pins[0])
                                                      : 1'b0;
            r_out_pin_b <= (r_timer_mode == MODE_PWM) ? drive_pin(r_out_b_mode, n_pins[1])
                                                      : 1'b0;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.count           = r_out_count;
    assign o_result.overflow_event  = r_out_ovf;
    assign o_result.compare_a_event = r_out_ca;
    assign o_result.compare_b_event = r_out_cb;
    assign o_result.pwm_out_a       = r_out_pin_a;
    assign o_result.pwm_out_b       = r_out_pin_b;
endmodule

FILE: hdl/tcp_checker.sv
// Port-level checker of the timer unit and its bind to the top level.
`timescale 1ns / 1ps
`include "timer_counter_pwm_postscaler_unit_macros.svh"

module tcp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tcp_pkg::COUNT_BITS-1:0] i_count,
    input logic                           i_ovf,
    input logic                           i_ca,
    input logic                           i_cb,
    input logic                           i_pin_a,
    input logic                           i_pin_b
);
    import tcp_pkg::*;

    // A stalled result holds its payload
    `TCP_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_count) && $stable(i_ovf) && $stable(i_ca) && $stable(i_cb) && $stable(i_pin_a) && $stable(i_pin_b))

    // An overflow always lands the count at zero
    `TCP_ASSERT_SAME(a_ovf_zero, i_out_valid && i_ovf, i_count == '0)

    // A new result only appears after an input transfer through the input register
    `TCP_ASSERT_SAME(a_result_src, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2))
endmodule

bind timer_counter_pwm_postscaler_unit tcp_checker u_tcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_count     (o_result.count),
    .i_ovf       (o_result.overflow_event),
    .i_ca        (o_result.compare_a_event),
    .i_cb        (o_result.compare_b_event),
    .i_pin_a     (o_result.pwm_out_a),
    .i_pin_b     (o_result.pwm_out_b)
);
